FILE: rtl/core/rlepd_pkg.sv
// Package for the run-length palette pixel decoder.
// Holds widths, byte codes, register indexes and the channel payload types.
// Used by the decoder modules other than the RAM and by the decoder's checker.
package rlepd_pkg;

	localparam int PALETTE_DEPTH = 128;
	localparam int COLOR_WIDTH   = 16;
	localparam int INDEX_WIDTH   = 7;
	localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int RUN_LEN_W     = 9;
	localparam int OUT_COLOR_W   = 16;

	// Operation codes of an input item.
	localparam logic OP_PIXEL_BYTE    = 1'b0;
	localparam logic OP_PALETTE_WRITE = 1'b1;

	// Byte codes of the compressed stream.
	localparam logic [7:0] RUN_FLAG = 8'h80;
	localparam logic [7:0] END_BYTE = 8'hFF;

	// Configuration register indexes.
	localparam logic CFG_REPLACE_INDEX    = 1'b0;
	localparam logic CFG_BACKGROUND_INDEX = 1'b1;

	localparam logic [RUN_LEN_W-1:0] MAX_RUN_LEN = 9'd257;

	typedef struct packed {
		logic        op;
		logic [7:0]  code_byte;
		logic [6:0]  palette_slot;
		logic [15:0] palette_value;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic [8:0]  run_length;
		logic        picture_end;
	} run_item_t;

	// Result waiting for its palette read data.
	typedef struct packed {
		logic                 valid;
		logic [RUN_LEN_W-1:0] run_length;
		logic                 picture_end;
		logic                 zero_color;
	} pend_t;

endpackage

FILE: rtl/core/rlepd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; depends on nothing.
module rlepd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/rlepd_parse.sv
// Byte parser of the decoder: run/count state, index substitution and palette access.
// Depends on rlepd_pkg; drives the palette RAM and the pending-result stage.
module rlepd_parse import rlepd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  byte_item_t             item,
	input  logic [INDEX_WIDTH-1:0] replace_index,
	input  logic [INDEX_WIDTH-1:0] background_index,
	input  logic                   pend_free,
	output pend_t                  pend,
	output logic                   wr_en,
	output logic [PAL_ADDR_W-1:0]  wr_addr,
	output logic [COLOR_WIDTH-1:0] wr_data,
	output logic                   rd_en,
	output logic [PAL_ADDR_W-1:0]  rd_addr
);

	logic                   awaiting_q;
	logic [INDEX_WIDTH-1:0] held_q;
	logic                   valid_s1;
	logic [RUN_LEN_W-1:0]   len_s1;
	logic                   end_s1;
	logic                   zero_s1;

	logic                   is_write;
	logic                   is_end;
	logic                   is_header;
	logic                   emit;
	logic [INDEX_WIDTH-1:0] idx;
	logic [INDEX_WIDTH-1:0] eff;
	logic [RUN_LEN_W-1:0]   len;
	logic                   eff_in_range;
	logic                   slot_in_range;
	logic [31:0]            value_wide;

	always_comb begin
		is_write  = (item.op == OP_PALETTE_WRITE);
		is_end    = !awaiting_q && (item.code_byte == END_BYTE);
		is_header = !awaiting_q && !is_end && ((item.code_byte & RUN_FLAG) != 8'h00);
		emit      = accept && !is_write && !is_header;
		if (awaiting_q) begin
			idx = held_q;
			len = RUN_LEN_W'({1'b0, item.code_byte}) + RUN_LEN_W'(2);
		end else begin
			idx = item.code_byte[INDEX_WIDTH-1:0];
			len = RUN_LEN_W'(1);
		end
		eff           = (idx == replace_index) ? background_index : idx;
		eff_in_range  = ({1'b0, eff} < (INDEX_WIDTH+1)'(PALETTE_DEPTH));
		slot_in_range = ({1'b0, item.palette_slot} < (INDEX_WIDTH+1)'(PALETTE_DEPTH));
		value_wide    = {16'h0000, item.palette_value};
	end

	assign wr_en   = accept && is_write && slot_in_range;
	assign wr_addr = item.palette_slot[PAL_ADDR_W-1:0];
	assign wr_data = value_wide[COLOR_WIDTH-1:0];
	assign rd_en   = emit && !is_end && eff_in_range;
	assign rd_addr = eff[PAL_ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			held_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept && !is_write) begin
				awaiting_q <= is_header;
				if (is_header) begin
					held_q <= item.code_byte[INDEX_WIDTH-1:0];
				end
			end
			if (pend_free) begin
				valid_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			len_s1  <= is_end ? '0 : len;
			end_s1  <= is_end;
			zero_s1 <= is_end || !eff_in_range;
		end
	end

	assign pend.valid       = valid_s1;
	assign pend.run_length  = len_s1;
	assign pend.picture_end = end_s1;
	assign pend.zero_color  = zero_s1;

endmodule

FILE: rtl/core/rlepd_out.sv
// Output register of the decoder: joins the palette color with the pending run.
// Depends on rlepd_pkg; fed by rlepd_parse and the palette RAM.
module rlepd_out import rlepd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pend_t                  pend,
	input  logic [COLOR_WIDTH-1:0] color,
	input  logic                   run_stall,
	output logic                   pend_load,
	output logic                   run_valid,
	output run_item_t              run_item
);

	logic        out_valid_q;
	run_item_t   out_item_q;
	logic [31:0] color_wide;

	assign color_wide = 32'(color);
	assign pend_load  = pend.valid && (!out_valid_q || !run_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_load) begin
			out_valid_q <= 1'b1;
		end else if (!run_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			out_item_q.pixel_color <= pend.zero_color ? '0 : color_wide[OUT_COLOR_W-1:0];
			out_item_q.run_length  <= pend.run_length;
			out_item_q.picture_end <= pend.picture_end;
		end
	end

	assign run_valid = out_valid_q;
	assign run_item  = out_item_q;

endmodule

FILE: rtl/core/rle_palette_pixel_decoder_core.sv
// Top level of the run-length palette pixel decoder.
// Depends on rlepd_pkg, rlepd_parse, rlepd_ram and rlepd_out.

// The decoder takes one item per clock cycle on the byte channel unless it
// stalls: either a compressed picture byte or a palette entry write, and gives
// one result per run on the run channel, carrying the color and the number of
// pixels, or an end-of-picture result with zero color and zero length. In the
// accepting cycle the parser resolves the index (with the replace index swapped
// for the background index) and reads the palette RAM. The run length waits in
// the pending stage until the output register is free or its result is being
// taken; the read data and the run length are then loaded into the output
// register, which drives the run channel. The sustained rate is one transfer
// per cycle while the run channel is not stalled, set by the single read port
// and single write port of the palette RAM; a palette write and a lookup never
// fall in the same cycle, and a lookup issued right after a write to the same
// entry already sees the new color. Palette writes and run header bytes give no
// result. The byte channel stalls only while a result is parked in the output
// register, the next one is waiting on its read data and the run channel is
// stalled. The palette holds no reset value: a picture must only use entries
// that were written before. Configuration writes are always ready and should
// only be issued while no transfer is in flight.
module rle_palette_pixel_decoder_core import rlepd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  byte_item_t             byte_item,
	output logic                   run_valid,
	input  logic                   run_stall,
	output run_item_t              run_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [INDEX_WIDTH-1:0] cfg_data
);

	logic [INDEX_WIDTH-1:0] replace_q;
	logic [INDEX_WIDTH-1:0] background_q;

	pend_t                  pend;
	logic                   pend_load;
	logic                   pend_free;
	logic                   accept;
	logic                   wr_en;
	logic [PAL_ADDR_W-1:0]  wr_addr;
	logic [COLOR_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [PAL_ADDR_W-1:0]  rd_addr;
	logic [COLOR_WIDTH-1:0] rd_data;

	// The pending stage is free when empty or when it moves to the output
	// register in this cycle, so the RAM read data is consumed before reuse.
	assign pend_free  = !pend.valid || pend_load;
	assign byte_stall = !pend_free;
	assign accept     = byte_valid && !byte_stall;

	// Configuration registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q    <= '0;
			background_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REPLACE_INDEX: begin
					replace_q <= cfg_data;
				end
				CFG_BACKGROUND_INDEX: begin
					background_q <= cfg_data;
				end
				default: begin
					replace_q <= replace_q;
				end
			endcase
		end
	end

	rlepd_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.item             (byte_item),
		.replace_index    (replace_q),
		.background_index (background_q),
		.pend_free        (pend_free),
		.pend             (pend),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr)
	);

	rlepd_ram #(
		.WIDTH (COLOR_WIDTH),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rlepd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pend      (pend),
		.color     (rd_data),
		.run_stall (run_stall),
		.pend_load (pend_load),
		.run_valid (run_valid),
		.run_item  (run_item)
	);

endmodule

FILE: rtl/core/rlepd_checker.sv
// Port-level checker for the run-length palette pixel decoder.
// Depends on rlepd_pkg; bound to rle_palette_pixel_decoder_core.
module rlepd_checker import rlepd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       run_valid,
	input logic       run_stall,
	input run_item_t  run_item
);

	// A stalled result stays put until it is taken.
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_stall |=> run_valid && $stable(run_item))
		else $error("run result changed while stalled");

	// The end result carries neither color nor pixels.
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_item.picture_end |->
			run_item.run_length == '0 && run_item.pixel_color == '0)
		else $error("end result with nonzero color or length");

	// Every run has at least one pixel and at most a full counted run.
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_item.picture_end |->
			run_item.run_length != '0 && run_item.run_length <= MAX_RUN_LEN)
		else $error("run length out of range");

endmodule

bind rle_palette_pixel_decoder_core rlepd_checker u_rlepd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.run_valid (run_valid),
	.run_stall (run_stall),
	.run_item  (run_item)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for rle_palette_pixel_decoder_core.
// Drives picture bytes and palette writes and checks every run against a directed table
// row or a palette decoder model kept here; depends only on rlepd_pkg and the decoder RTL.
module tb_top;
	import rlepd_pkg::*;

	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 150;
	localparam int QUIET_LIMIT    = 2000;

	// One row of the directed table. When has_known is set, the run that the row
	// must give is written out in the row; otherwise the decoder model supplies it.
	typedef struct packed {
		byte_item_t item;
		logic       has_known;
		run_item_t  known_run;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   byte_valid = 1'b0;
	logic                   byte_stall;
	byte_item_t             byte_item = '0;
	logic                   run_valid;
	logic                   run_stall = 1'b0;
	run_item_t              run_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = CFG_REPLACE_INDEX;
	logic [INDEX_WIDTH-1:0] cfg_data = '0;

	// Decoder model state: palette, which entries hold a color, the pending run
	// header and the two index registers.
	logic [15:0]            pal_color [PALETTE_DEPTH];
	bit                     pal_written [PALETTE_DEPTH];
	bit                     count_pending = 1'b0;
	logic [6:0]             held_idx = '0;
	logic [6:0]             replace_sel = '0;
	logic [6:0]             background_sel = '0;

	run_item_t              runs_due [$];
	stim_row_t              dir_rows [$];

	// Row currently offered on the byte channel, seen by the scoreboard.
	bit                     cur_known = 1'b0;
	run_item_t              cur_known_run = '0;

	int                     fault_count = 0;
	int                     quiet_cycles = 0;
	int                     items_sent = 0;
	bit                     tx_idling = 1'b1;
	bit                     rx_idling = 1'b1;
	bit                     hold_request = 1'b0;

	rle_palette_pixel_decoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.run_valid  (run_valid),
		.run_stall  (run_stall),
		.run_item   (run_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// Color of a palette index, with the replace index swapped for the background one.
	function automatic logic [15:0] palette_color(logic [6:0] idx);
		logic [6:0] eff;
		eff = (idx == replace_sel) ? background_sel : idx;
		return pal_color[eff];
	endfunction

	// Advances the decoder model by one accepted item and tells whether a run comes out.
	task automatic decode_item(input byte_item_t it, output bit made, output run_item_t run);
		made = 1'b0;
		run = '0;
		if (it.op == OP_PALETTE_WRITE) begin
			pal_color[it.palette_slot] = it.palette_value;
			pal_written[it.palette_slot] = 1'b1;
		end else if (count_pending) begin
			// Any byte after a run header is its count, the end code included.
			count_pending = 1'b0;
			made = 1'b1;
			run.pixel_color = palette_color(held_idx);
			run.run_length = {1'b0, it.code_byte} + 9'd2;
		end else if (it.code_byte == END_BYTE) begin
			made = 1'b1;
			run.picture_end = 1'b1;
		end else if ((it.code_byte & RUN_FLAG) != 0) begin
			held_idx = it.code_byte[6:0];
			count_pending = 1'b1;
		end else begin
			made = 1'b1;
			run.pixel_color = palette_color(it.code_byte[6:0]);
			run.run_length = 9'd1;
		end
	endtask

	function automatic byte_item_t pixel_byte(logic [7:0] code);
		byte_item_t it;
		it.op = OP_PIXEL_BYTE;
		it.code_byte = code;
		it.palette_slot = 7'($urandom_range(0, 127));
		it.palette_value = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic byte_item_t palette_write(logic [6:0] slot, logic [15:0] color);
		byte_item_t it;
		it.op = OP_PALETTE_WRITE;
		it.code_byte = 8'($urandom_range(0, 255));
		it.palette_slot = slot;
		it.palette_value = color;
		return it;
	endfunction

	function automatic stim_row_t row_plain(byte_item_t it);
		stim_row_t r;
		r = '0;
		r.item = it;
		return r;
	endfunction

	function automatic stim_row_t row_known(logic [7:0] code, logic [15:0] color,
			logic [8:0] len, logic done);
		stim_row_t r;
		r.item = pixel_byte(code);
		r.has_known = 1'b1;
		r.known_run.pixel_color = color;
		r.known_run.run_length = len;
		r.known_run.picture_end = done;
		return r;
	endfunction

	// Offers one item, with a random gap before it when idling is on, and returns
	// at the falling edge after its transfer with valid still high.
	task automatic send_item(input byte_item_t it, input bit known, input run_item_t known_run);
		int gap;
		if (tx_idling && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 10);
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_item <= it;
		byte_valid <= 1'b1;
		cur_known = known;
		cur_known_run = known_run;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends a picture byte. A literal or run header only names palette entries that
	// hold a color: a missing one is written first.
	task automatic send_pixel(input logic [7:0] code);
		logic [6:0] eff;
		if (!count_pending && code != END_BYTE) begin
			eff = (code[6:0] == replace_sel) ? background_sel : code[6:0];
			if (!pal_written[eff])
				send_item(palette_write(eff, 16'($urandom_range(0, 65535))), 1'b0, '0);
		end
		send_item(pixel_byte(code), 1'b0, '0);
	endtask

	// Stops offering and waits until every run expected so far has come out.
	task automatic wait_drained;
		byte_valid <= 1'b0;
		do @(negedge clk); while (runs_due.size() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_REPLACE_INDEX)
			replace_sel = value;
		else
			background_sel = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Scoreboard: at each rising edge, a byte transfer feeds the model and a run
	// transfer is checked against the oldest expected run.
	always @(posedge clk) begin : scoreboard
		bit        made;
		run_item_t predicted;
		run_item_t due;
		if (arst_n) begin
			quiet_cycles++;
			if (byte_valid && !byte_stall) begin
				quiet_cycles = 0;
				decode_item(byte_item, made, predicted);
				if (made)
					runs_due.push_back(cur_known ? cur_known_run : predicted);
			end
			if (run_valid && !run_stall) begin
				quiet_cycles = 0;
				if (runs_due.size() == 0) begin
					$error("run_item: no run expected, got %h", run_item);
					fault_count++;
				end else begin
					due = runs_due.pop_front();
					if (run_item.pixel_color !== due.pixel_color) begin
						$error("pixel_color: expected %h, got %h",
							due.pixel_color, run_item.pixel_color);
						fault_count++;
					end
					if (run_item.run_length !== due.run_length) begin
						$error("run_length: expected %0d, got %0d",
							due.run_length, run_item.run_length);
						fault_count++;
					end
					if (run_item.picture_end !== due.picture_end) begin
						$error("picture_end: expected %b, got %b",
							due.picture_end, run_item.picture_end);
						fault_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				quiet_cycles = 0;
		end
	end

	// Run channel receiver: random stall bursts, plus one long hold-off on request
	// that lets the decoder fill up and push back on the byte channel.
	initial begin : run_sink
		int burst;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				run_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				run_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (rx_idling && $urandom_range(0, 99) < 30) begin
				burst = $urandom_range(1, 10);
				run_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				run_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int         pick;
		int         phase_goal;
		bit         paused;
		logic [6:0] rep;
		logic [6:0] bg;

		foreach (pal_written[i])
			pal_written[i] = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under replace 5 -> background 127.
		write_reg(CFG_REPLACE_INDEX, 7'd5);
		write_reg(CFG_BACKGROUND_INDEX, 7'd127);

		dir_rows.push_back(row_plain(palette_write(7'd0, 16'h0000)));
		dir_rows.push_back(row_plain(palette_write(7'd127, 16'hFFFF)));
		dir_rows.push_back(row_plain(palette_write(7'd1, 16'hA5C3)));
		// Entry 5 is never shown while 5 is the replace index.
		dir_rows.push_back(row_plain(palette_write(7'd5, 16'h1234)));
		dir_rows.push_back(row_known(8'h00, 16'h0000, 9'd1, 1'b0));
		dir_rows.push_back(row_known(8'h7F, 16'hFFFF, 9'd1, 1'b0));
		dir_rows.push_back(row_plain(pixel_byte(8'h01)));
		dir_rows.push_back(row_known(8'h05, 16'hFFFF, 9'd1, 1'b0));
		dir_rows.push_back(row_known(END_BYTE, 16'h0000, 9'd0, 1'b1));
		// Shortest run: header then count zero.
		dir_rows.push_back(row_plain(pixel_byte(8'h80)));
		dir_rows.push_back(row_known(8'h00, 16'h0000, 9'd2, 1'b0));
		// The end code taken as a count gives the longest run.
		dir_rows.push_back(row_plain(pixel_byte(8'h81)));
		dir_rows.push_back(row_known(END_BYTE, 16'hA5C3, 9'd257, 1'b0));
		// A palette write between header and count keeps the count pending and
		// the new color is the one shown.
		dir_rows.push_back(row_plain(palette_write(7'd126, 16'h5A5A)));
		dir_rows.push_back(row_plain(pixel_byte(8'hFE)));
		dir_rows.push_back(row_plain(palette_write(7'd126, 16'h0F0F)));
		dir_rows.push_back(row_known(8'h7F, 16'h0F0F, 9'd129, 1'b0));
		dir_rows.push_back(row_plain(pixel_byte(8'h85)));
		dir_rows.push_back(row_known(8'h10, 16'hFFFF, 9'd18, 1'b0));
		// A new picture starts right after the end.
		dir_rows.push_back(row_known(END_BYTE, 16'h0000, 9'd0, 1'b1));
		dir_rows.push_back(row_plain(pixel_byte(8'h01)));

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].has_known, dir_rows[i].known_run);

		// Random phases, each under its own register setting.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin rep = 7'd0;   bg = 7'd0;   end
				1: begin rep = 7'd127; bg = 7'd0;   end
				2: begin rep = 7'd42;  bg = 7'd85;  end
				3: begin rep = 7'd127; bg = 7'd127; end
				default: begin rep = 7'd0; bg = 7'd127; end
			endcase
			wait_drained();
			repeat (SETTLE_CYCLES) @(negedge clk);
			write_reg(CFG_REPLACE_INDEX, rep);
			write_reg(CFG_BACKGROUND_INDEX, bg);

			if (p == 1) begin
				// Long receiver hold-off while literals keep coming back to back.
				tx_idling = 1'b0;
				hold_request = 1'b1;
				repeat (30) send_pixel({1'b0, 7'($urandom_range(0, 127))});
				tx_idling = 1'b1;
			end
			if (p == 4) begin
				tx_idling = 1'b0;
				rx_idling = 1'b0;
			end

			phase_goal = items_sent + PHASE_ITEMS;
			paused = 1'b0;
			while (items_sent < phase_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					send_item(palette_write(7'($urandom_range(0, 127)),
						16'($urandom_range(0, 65535))), 1'b0, '0);
				end else if (pick < 55) begin
					send_pixel({1'b0, 7'($urandom_range(0, 127))});
				end else if (pick < 85) begin
					send_pixel(RUN_FLAG | {1'b0, 7'($urandom_range(0, 126))});
					if ($urandom_range(0, 9) == 0)
						send_item(palette_write(7'($urandom_range(0, 127)),
							16'($urandom_range(0, 65535))), 1'b0, '0);
					send_pixel(8'($urandom_range(0, 255)));
				end else if (pick < 90) begin
					send_pixel(END_BYTE);
				end else begin
					// Any byte at all, which may leave a header waiting for its count.
					send_pixel(8'($urandom_range(0, 255)));
				end
				if (p == 2 && !paused && items_sent >= phase_goal - PHASE_ITEMS / 2) begin
					// Sender holds back until every run so far has come out.
					paused = 1'b1;
					wait_drained();
				end
			end
			// Close a pending run so the registers change with the decoder idle.
			if (count_pending)
				send_pixel(8'($urandom_range(0, 255)));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
